// ===== sv/assert_macros.svh =====
// assertion macros shared by the tag stripper modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is asserted
`define HTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also holds during reset
`define HTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/hts_pkg.sv =====
// types, constants and the prefix compare for the tag stripper
package hts_pkg;

  localparam int NAME_KEEP = 7;
  localparam int NAME_SAT  = 8;
  localparam int LEN_W     = 4;
  localparam int PAT_W     = 8 * NAME_KEEP;

  localparam logic [7:0] CH_OPEN    = 8'h3C;  // '<'
  localparam logic [7:0] CH_CLOSE   = 8'h3E;  // '>'
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFS   = 8'h20;

  // string literals, right aligned: first char sits highest
  localparam logic [PAT_W-1:0] PAT_SCRIPT     = PAT_W'("script");
  localparam logic [PAT_W-1:0] PAT_END_SCRIPT = PAT_W'("/script");
  localparam logic [PAT_W-1:0] PAT_STYLE      = PAT_W'("style");
  localparam logic [PAT_W-1:0] PAT_END_STYLE  = PAT_W'("/style");
  localparam logic [PAT_W-1:0] PAT_END_P      = PAT_W'("/p");
  localparam logic [PAT_W-1:0] PAT_END_DIV    = PAT_W'("/div");
  localparam logic [PAT_W-1:0] PAT_END_H      = PAT_W'("/h");
  localparam logic [PAT_W-1:0] PAT_END_LI     = PAT_W'("/li");
  localparam logic [PAT_W-1:0] PAT_BR         = PAT_W'("br");
  localparam logic [PAT_W-1:0] PAT_BR_SLASH   = PAT_W'("br/");

  typedef logic [7:0] name_t [NAME_KEEP];

  typedef struct packed {
    logic script_on;
    logic script_off;
    logic style_on;
    logic style_off;
    logic newline;
  } tag_hits_t;

  typedef struct packed {
    logic       txt_valid;
    logic [7:0] data;
    logic       last;
  } result_t;

  // true when the stored name begins with the n-char pattern
  function automatic logic name_starts(name_t nm, logic [LEN_W-1:0] len,
                                       logic [PAT_W-1:0] pat, int n);
    logic hit;
    int   pos;
    hit = (len >= LEN_W'(n));
    for (int i = 0; i < NAME_KEEP; i++) begin
      pos = n - 1 - i;
      if (i < n && pos >= 0) begin
        if (nm[i] != pat[pos*8 +: 8]) begin
          hit = 1'b0;
        end
      end
    end
    return hit;
  endfunction

endpackage

// ===== sv/hts_name_match.sv =====
// classifies the stored tag name against the known tag prefixes
module hts_name_match
  import hts_pkg::*;
(
  input  name_t            name_i,
  input  logic [LEN_W-1:0] len_i,
  output tag_hits_t        hits_o
);

  logic is_br;
  logic is_br_slash;

  assign is_br       = (len_i == LEN_W'(2)) && name_starts(name_i, len_i, PAT_BR, 2);
  assign is_br_slash = (len_i == LEN_W'(3)) && name_starts(name_i, len_i, PAT_BR_SLASH, 3);

  always_comb begin
    hits_o.script_on  = name_starts(name_i, len_i, PAT_SCRIPT, 6);
    hits_o.script_off = name_starts(name_i, len_i, PAT_END_SCRIPT, 7);
    hits_o.style_on   = name_starts(name_i, len_i, PAT_STYLE, 5);
    hits_o.style_off  = name_starts(name_i, len_i, PAT_END_STYLE, 6);
    hits_o.newline    = name_starts(name_i, len_i, PAT_END_P, 2)
                      | name_starts(name_i, len_i, PAT_END_DIV, 4)
                      | name_starts(name_i, len_i, PAT_END_H, 2)
                      | name_starts(name_i, len_i, PAT_END_LI, 3)
                      | is_br | is_br_slash;
  end

endmodule

// ===== sv/hts_core.sv =====
// parser state and per-item decision logic of the tag stripper
`include "assert_macros.svh"

module hts_core
  import hts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output result_t    res_o
);

  logic             tag_r, tag_nxt;
  logic             script_r, script_nxt;
  logic             style_r, style_nxt;
  name_t            name_r;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             wr_char;
  logic [7:0]       low_char;
  tag_hits_t        hits;

  hts_name_match u_match (
    .name_i (name_r),
    .len_i  (len_r),
    .hits_o (hits)
  );

  assign low_char = (byte_i >= CH_UPPER_A && byte_i <= CH_UPPER_Z) ?
                    byte_i + CASE_OFS : byte_i;

  always_comb begin
    tag_nxt       = tag_r;
    script_nxt    = script_r;
    style_nxt     = style_r;
    len_nxt       = len_r;
    wr_char       = 1'b0;
    res_o.txt_valid = 1'b0;
    res_o.data      = 8'h00;
    res_o.last      = last_i;
    if (byte_i == CH_OPEN) begin
      tag_nxt = 1'b1;
      len_nxt = '0;
    end else if (byte_i == CH_CLOSE) begin
      tag_nxt = 1'b0;
      if (hits.script_on)  script_nxt = 1'b1;
      if (hits.script_off) script_nxt = 1'b0;
      if (hits.style_on)   style_nxt  = 1'b1;
      if (hits.style_off)  style_nxt  = 1'b0;
      if (hits.newline) begin
        res_o.txt_valid = 1'b1;
        res_o.data      = CH_NEWLINE;
      end
    end else if (tag_r) begin
      wr_char = (len_r < LEN_W'(NAME_KEEP));
      if (len_r < LEN_W'(NAME_SAT)) len_nxt = len_r + LEN_W'(1);
    end else if (!script_r && !style_r) begin
      res_o.txt_valid = 1'b1;
      res_o.data      = byte_i;
    end
    // end of document returns to the reset state
    if (last_i) begin
      tag_nxt    = 1'b0;
      script_nxt = 1'b0;
      style_nxt  = 1'b0;
      len_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r    <= 1'b0;
      script_r <= 1'b0;
      style_r  <= 1'b0;
      len_r    <= '0;
    end else if (step_i) begin
      tag_r    <= tag_nxt;
      script_r <= script_nxt;
      style_r  <= style_nxt;
      len_r    <= len_nxt;
    end
  end

  // chars beyond the length are never compared, so no reset
  always_ff @(posedge clk) begin
    if (step_i && wr_char) begin
      name_r[len_r[2:0]] <= low_char;
    end
  end

  `HTS_ASSERT(a_len_sat, len_r <= LEN_W'(NAME_SAT), "name length beyond saturation")
  `HTS_ASSERT(a_doc_end_clear, step_i && last_i |=> !tag_r && !script_r && !style_r && len_r == '0, "state not cleared at document end")

endmodule

// ===== sv/html_tag_stripper_unit.sv =====
// an accepted input item is parsed from the input register and its result is presented from the result register
// throughput: one item per cycle while out_stall is low, set by the single pass through the parser state
// an input register and a result register part the two channels; stall propagates
// combinationally from out_stall to in_stall
// synchronous active-low reset clears parser state and the valid flags of both register stages
`include "assert_macros.svh"

module html_tag_stripper_unit
  import hts_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_item_valid,
  input  logic       out_stall,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic       s1_vld_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       o_vld_r;
  result_t    o_res_r;
  result_t    core_res;
  logic       adv;
  logic       s1_load;
  logic       step;

  // result stage moves when empty or taken
  assign adv      = !o_vld_r || !out_stall;
  assign in_stall = s1_vld_r && !adv;
  assign s1_load  = in_valid && !in_stall;
  assign step     = adv && s1_vld_r;

  hts_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step_i (step),
    .byte_i (s1_byte_r),
    .last_i (s1_last_r),
    .res_o  (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      o_vld_r  <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_vld_r <= 1'b1;
      end else if (adv) begin
        s1_vld_r <= 1'b0;
      end
      if (adv) begin
        o_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_last;
    end
    if (step) begin
      o_res_r <= core_res;
    end
  end

  assign out_item_valid = o_vld_r;
  assign out_valid      = o_res_r.txt_valid;
  assign out_byte       = o_res_r.data;
  assign out_last       = o_res_r.last;

  `HTS_ASSERT(a_stall_full, in_stall |-> s1_vld_r && o_vld_r && out_stall, "input stalled while a stage is free")
  `HTS_ASSERT(a_zero_byte, o_vld_r && !o_res_r.txt_valid |-> o_res_r.data == 8'h00, "byte not zero on a suppressed item")

endmodule
